/* hw/rtl/vnt_pkg.sv */
// ----------------------------------------------------------------------------
// vnt_pkg
// Shared types and constants of the vertex and normal transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnt_pkg;

  localparam int POS_FRAC_BITS = 16;

  localparam int M_ENTRIES = 12;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 32;
  localparam int NRM_W     = 16;
  localparam int ST_W      = 2;

  // Shared multiply-accumulate unit.
  localparam int OPD_W = 33;
  localparam int PRD_W = 2 * OPD_W;
  localparam int ACC_W = 100;

  // Normal path.
  localparam int COF_W = 65;
  localparam int MAG_W = 80;
  localparam int SQ_W  = 64;
  localparam int LEN_W = 32;
  localparam int QUO_W = 15;
  localparam int NUM_W = 47;
  localparam int UNIT_SH = 14;

  localparam logic [QUO_W-1:0] NRM_ONE = QUO_W'(16384);

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 2'd0,
    ST_SINGULAR    = 2'd1,
    ST_ZERO_NORMAL = 2'd2,
    ST_POS_SAT     = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_e;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic mul;
    logic acc_init;
    logic acc_add;
    logic acc_post;
    logic neg;
    logic sh32;
  } mac_ctl_t;

  typedef struct packed {
    logic go;
    logic div;
  } rdu_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/vnt_if.sv */
// ----------------------------------------------------------------------------
// vnt_in_if / vnt_out_if
// Valid-ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnt_in_if;
  import vnt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [VAL_W-1:0]  entry_value;
  logic signed [VAL_W-1:0]  pos_x;
  logic signed [VAL_W-1:0]  pos_y;
  logic signed [VAL_W-1:0]  pos_z;
  logic signed [NRM_W-1:0]  norm_x;
  logic signed [NRM_W-1:0]  norm_y;
  logic signed [NRM_W-1:0]  norm_z;

  modport source (output valid, opcode, entry_index, entry_value, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, opcode, entry_index, entry_value, pos_x, pos_y, pos_z,
                norm_x, norm_y, norm_z, output ready);
endinterface

interface vnt_out_if;
  import vnt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  out_pos_x;
  logic signed [VAL_W-1:0]  out_pos_y;
  logic signed [VAL_W-1:0]  out_pos_z;
  logic signed [NRM_W-1:0]  out_norm_x;
  logic signed [NRM_W-1:0]  out_norm_y;
  logic signed [NRM_W-1:0]  out_norm_z;
  logic [ST_W-1:0]          status;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
                  out_norm_z, status, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
                out_norm_z, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/vnt_mac.sv */
// ----------------------------------------------------------------------------
// vnt_mac
// Shared signed multiply-accumulate unit with operand and product registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vnt_mac (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  vnt_pkg::mac_ctl_t                      ctl_i,
  input  wire logic signed [vnt_pkg::OPD_W-1:0]  opnd_i,
  input  wire logic signed [vnt_pkg::ACC_W-1:0]  init_i,
  output logic signed [vnt_pkg::ACC_W-1:0]       acc_o
);
  import vnt_pkg::*;

  logic signed [OPD_W-1:0] a_q, b_q;
  logic signed [PRD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, prod_ext, addend;

  always_comb begin
    prod_ext = ACC_W'(prod_q);
    if (ctl_i.sh32) begin
      prod_ext = prod_ext <<< 32;
    end
    addend = ctl_i.neg ? -prod_ext : prod_ext;
    acc_d = acc_q;
    if (ctl_i.acc_init) begin
      acc_d = init_i;
    end else if (ctl_i.acc_add) begin
      acc_d = acc_q + addend;
    end else if (ctl_i.acc_post) begin
      // Drop the fraction bits of the rounded sum, then add the translation.
      acc_d = (acc_q >>> POS_FRAC_BITS) + init_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctl_i.ld_a) a_q <= opnd_i;
      if (ctl_i.ld_b) b_q <= opnd_i;
      if (ctl_i.mul)  prod_q <= a_q * b_q;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* hw/rtl/vnt_rdu.sv */
// ----------------------------------------------------------------------------
// vnt_rdu
// Bit-serial square root and restoring divider sharing one compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module vnt_rdu (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  vnt_pkg::rdu_cmd_t                cmd_i,
  input  wire logic [vnt_pkg::SQ_W-1:0]    rad_i,
  input  wire logic [vnt_pkg::NUM_W-1:0]   num_i,
  input  wire logic [vnt_pkg::LEN_W-1:0]   den_i,
  output logic                             busy_o,
  output logic [vnt_pkg::LEN_W-1:0]        root_o,
  output logic [vnt_pkg::QUO_W-1:0]        quo_o
);
  import vnt_pkg::*;

  logic            busy_q, div_q;
  logic [4:0]      cnt_q;
  logic [SQ_W-1:0] x_q, res_q, bit_q, trial;
  logic            ge;

  always_comb begin
    trial = div_q ? bit_q : res_q + bit_q;
    ge    = (x_q >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else if (cmd_i.go) begin
      busy_q <= 1'b1;
      div_q  <= cmd_i.div;
      res_q  <= '0;
      if (cmd_i.div) begin
        cnt_q <= 5'(QUO_W - 1);
        x_q   <= SQ_W'(num_i);
        bit_q <= SQ_W'(den_i) << (QUO_W - 1);
      end else begin
        cnt_q <= 5'(LEN_W - 1);
        x_q   <= rad_i;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
    end else if (busy_q) begin
      if (ge) x_q <= x_q - trial;
      if (div_q) begin
        res_q <= {res_q[SQ_W-2:0], ge};
        bit_q <= bit_q >> 1;
      end else begin
        res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
        bit_q <= bit_q >> 2;
      end
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 5'd1;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[LEN_W-1:0];
  assign quo_o  = res_q[QUO_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/vertex_normal_transform.sv */
// ----------------------------------------------------------------------------
// vertex_normal_transform
// Affine vertex transform with cofactor normal transform and renormalization.
// ----------------------------------------------------------------------------
// A load item is taken while idle and gives no result.
// A transform item uses one multiply-accumulate unit, which carries 54 products, and
// a bit-serial unit, which gives the square root (32 steps) and three quotients
// (15 each). A singular matrix or a zero normal skips the root and quotients.
// One item is in work at a time; another is taken only once the result is accepted.
// Reset is asynchronous and loads the identity matrix.
`default_nettype none

module vertex_normal_transform (
  input  wire       clk_i,
  input  wire       rst_ni,
  vnt_in_if.sink    in_i,
  vnt_out_if.source out_o
);
  import vnt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_COF, S_DET, S_VEC, S_CHK, S_NORM, S_SQ,
    S_SQRT, S_SQRT_W, S_DIV, S_DIV_W, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    SRC_M, SRC_P, SRC_N, SRC_CH, SRC_CL, SRC_U
  } src_e;

  localparam logic [2:0] PH_A = 3'd0, PH_B = 3'd1, PH_MUL = 3'd2, PH_ACC = 3'd3,
                         PH_POST = 3'd4, PH_STORE = 3'd5;

  state_e state_q;
  logic [2:0] ph_q, term_q, last_term;
  logic [3:0] grp_q, last_grp;

  logic signed [VAL_W-1:0] m_q [M_ENTRIES];
  logic signed [VAL_W-1:0] p_q [3];
  logic signed [NRM_W-1:0] n_q [3];
  logic [COF_W-1:0]        cof_q [9];
  logic [MAG_W-1:0]        mag_q [3];
  logic [2:0]              vneg_q;
  logic                    det_neg_q, det_zero_q, sat_q;
  logic [SQ_W-1:0]         sq_q;
  logic [LEN_W-1:0]        len_q;
  logic signed [VAL_W-1:0] pos_q [3];
  logic signed [NRM_W-1:0] nrm_q [3];
  logic [ST_W-1:0]         status_q;

  mac_ctl_t                mac_ctl;
  rdu_cmd_t                rdu_cmd;
  logic signed [OPD_W-1:0] opnd;
  logic signed [ACC_W-1:0] mac_init, acc;
  logic                    rdu_busy;
  logic [LEN_W-1:0]        root;
  logic [QUO_W-1:0]        quo;
  logic [NUM_W-1:0]        num;

  logic                    mac_state;
  src_e                    src;
  logic [3:0]              idx;
  logic [1:0]              gr, tc, kr, kc, r1, r2, c1, c2;
  logic [3:0]              k3;

  function automatic logic [1:0] add3(input logic [1:0] x, input logic [1:0] s);
    logic [2:0] t;
    t = 3'(x) + 3'(s);
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    gr = grp_q[1:0];
    tc = term_q[2:1];
    kr = (grp_q >= 4'd6) ? 2'd2 : (grp_q >= 4'd3) ? 2'd1 : 2'd0;
    k3 = {1'b0, kr, 1'b0} + {2'b00, kr};
    kc = 2'(grp_q - k3);
    r1 = add3(kr, 2'd1);
    r2 = add3(kr, 2'd2);
    c1 = add3(kc, 2'd1);
    c2 = add3(kc, 2'd2);
    src = SRC_M;
    idx = '0;
    unique case (state_q)
      S_POS: begin
        if (ph_q == PH_A) begin
          src = SRC_M; idx = {gr, term_q[1:0]};
        end else begin
          src = SRC_P; idx = {2'b00, term_q[1:0]};
        end
      end
      S_COF: begin
        src = SRC_M;
        if (ph_q == PH_A) idx = term_q[0] ? {r1, c2} : {r1, c1};
        else              idx = term_q[0] ? {r2, c1} : {r2, c2};
      end
      S_DET: begin
        if (ph_q == PH_A) begin
          src = term_q[0] ? SRC_CL : SRC_CH; idx = {2'b00, tc};
        end else begin
          src = SRC_M; idx = {2'b00, tc};
        end
      end
      S_VEC: begin
        if (ph_q == PH_A) begin
          src = term_q[0] ? SRC_CL : SRC_CH;
          idx = {1'b0, gr, 1'b0} + {2'b00, gr} + {2'b00, tc};
        end else begin
          src = SRC_N; idx = {2'b00, tc};
        end
      end
      S_SQ: begin
        src = SRC_U; idx = {2'b00, term_q[1:0]};
      end
      default: ;
    endcase
    unique case (src)
      SRC_M:  opnd = OPD_W'(m_q[idx]);
      SRC_P:  opnd = OPD_W'(p_q[idx[1:0]]);
      SRC_N:  opnd = OPD_W'(n_q[idx[1:0]]);
      SRC_CH: opnd = $signed(cof_q[idx][COF_W-1:32]);
      SRC_CL: opnd = $signed({1'b0, cof_q[idx][31:0]});
      SRC_U:  opnd = $signed(mag_q[idx[1:0]][OPD_W-1:0]);
      default: opnd = '0;
    endcase
  end

  always_comb begin
    mac_state = (state_q == S_POS) || (state_q == S_COF) || (state_q == S_DET) ||
                (state_q == S_VEC) || (state_q == S_SQ);
    unique case (state_q)
      S_POS:   begin last_term = 3'd2; last_grp = 4'd2; end
      S_COF:   begin last_term = 3'd1; last_grp = 4'd8; end
      S_DET:   begin last_term = 3'd5; last_grp = 4'd0; end
      S_VEC:   begin last_term = 3'd5; last_grp = 4'd2; end
      default: begin last_term = 3'd2; last_grp = 4'd0; end
    endcase
    mac_ctl.ld_a     = mac_state && (ph_q == PH_A);
    mac_ctl.ld_b     = mac_state && (ph_q == PH_B);
    mac_ctl.mul      = mac_state && (ph_q == PH_MUL);
    mac_ctl.acc_add  = mac_state && (ph_q == PH_ACC);
    mac_ctl.acc_init = mac_state && (ph_q == PH_A) && (term_q == '0);
    mac_ctl.acc_post = (state_q == S_POS) && (ph_q == PH_POST);
    mac_ctl.neg      = (state_q == S_COF) && term_q[0];
    mac_ctl.sh32     = ((state_q == S_DET) || (state_q == S_VEC)) && !term_q[0];
    if (ph_q == PH_POST) mac_init = ACC_W'(m_q[{gr, 2'd3}]);
    else if (state_q == S_POS) mac_init = ACC_W'(1) <<< (POS_FRAC_BITS - 1);
    else mac_init = '0;
    rdu_cmd.go  = (state_q == S_SQRT) || (state_q == S_DIV);
    rdu_cmd.div = (state_q == S_DIV);
    num = NUM_W'({mag_q[gr][29:0], {UNIT_SH{1'b0}}}) + NUM_W'(len_q[LEN_W-1:1]);
  end

  vnt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .opnd_i (opnd),
    .init_i (mac_init),
    .acc_o  (acc)
  );

  vnt_rdu u_rdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rdu_cmd),
    .rad_i  (sq_q),
    .num_i  (num),
    .den_i  (len_q),
    .busy_o (rdu_busy),
    .root_o (root),
    .quo_o  (quo)
  );

  logic                    fits;
  logic signed [VAL_W-1:0] sat_val;
  logic signed [ACC_W-1:0] acc_abs;
  logic [MAG_W-1:0]        mag_or;
  logic [QUO_W-1:0]        q_clamp;
  logic signed [NRM_W-1:0] q_signed;

  always_comb begin
    fits = (&acc[ACC_W-1:VAL_W-1]) || !(|acc[ACC_W-1:VAL_W-1]);
    if (fits) sat_val = acc[VAL_W-1:0];
    else if (acc[ACC_W-1]) sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    else sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    acc_abs  = acc[ACC_W-1] ? -acc : acc;
    mag_or   = mag_q[0] | mag_q[1] | mag_q[2];
    q_clamp  = (quo > NRM_ONE) ? NRM_ONE : quo;
    q_signed = (vneg_q[gr] ^ det_neg_q) ? -$signed({1'b0, q_clamp})
                                        : $signed({1'b0, q_clamp});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ph_q       <= PH_A;
      term_q     <= '0;
      grp_q      <= '0;
      for (int i = 0; i < M_ENTRIES; i++) begin
        m_q[i] <= (i == 0 || i == 5 || i == 10) ? VAL_W'(1) <<< POS_FRAC_BITS : '0;
      end
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= '0; n_q[i] <= '0; mag_q[i] <= '0; pos_q[i] <= '0; nrm_q[i] <= '0;
      end
      for (int i = 0; i < 9; i++) cof_q[i] <= '0;
      vneg_q     <= '0;
      det_neg_q  <= 1'b0;
      det_zero_q <= 1'b0;
      sat_q      <= 1'b0;
      sq_q       <= '0;
      len_q      <= '0;
      status_q   <= ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            if (in_i.opcode == OP_LOAD) begin
              if (in_i.entry_index < IDX_W'(M_ENTRIES)) m_q[in_i.entry_index] <= in_i.entry_value;
            end else begin
              p_q[0] <= in_i.pos_x; p_q[1] <= in_i.pos_y; p_q[2] <= in_i.pos_z;
              n_q[0] <= in_i.norm_x; n_q[1] <= in_i.norm_y; n_q[2] <= in_i.norm_z;
              sat_q   <= 1'b0;
              ph_q    <= PH_A;
              term_q  <= '0;
              grp_q   <= '0;
              state_q <= S_POS;
            end
          end
        end
        S_POS, S_COF, S_DET, S_VEC, S_SQ: begin
          if (ph_q == PH_ACC) begin
            if (term_q != last_term) begin
              term_q <= term_q + 3'd1;
              ph_q   <= PH_A;
            end else begin
              ph_q <= (state_q == S_POS) ? PH_POST : PH_STORE;
            end
          end else if (ph_q == PH_STORE) begin
            unique case (state_q)
              S_POS: begin
                pos_q[gr] <= sat_val;
                if (!fits) sat_q <= 1'b1;
              end
              S_COF: cof_q[grp_q] <= acc[COF_W-1:0];
              S_DET: begin
                det_neg_q  <= acc[ACC_W-1];
                det_zero_q <= (acc == '0);
              end
              S_VEC: begin
                vneg_q[gr] <= acc[ACC_W-1];
                mag_q[gr]  <= acc_abs[MAG_W-1:0];
              end
              default: sq_q <= acc[SQ_W-1:0];
            endcase
            ph_q   <= PH_A;
            term_q <= '0;
            if (grp_q != last_grp) begin
              grp_q <= grp_q + 4'd1;
            end else begin
              grp_q <= '0;
              unique case (state_q)
                S_POS:   state_q <= S_COF;
                S_COF:   state_q <= S_DET;
                S_DET:   state_q <= S_VEC;
                S_VEC:   state_q <= S_CHK;
                default: state_q <= S_SQRT;
              endcase
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        S_CHK: begin
          if (det_zero_q) begin
            status_q <= ST_SINGULAR;
            for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
            state_q  <= S_OUT;
          end else if (mag_or == '0) begin
            status_q <= ST_ZERO_NORMAL;
            for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          // Bring the largest magnitude down to 30 bits, all by the same shift.
          if (|mag_or[MAG_W-1:38]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 8;
          end else if (|mag_or[MAG_W-1:30]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else begin
            ph_q    <= PH_A;
            term_q  <= '0;
            grp_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQRT: state_q <= S_SQRT_W;
        S_SQRT_W: begin
          if (!rdu_busy) begin
            len_q   <= (root == '0) ? LEN_W'(1) : root;
            grp_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: state_q <= S_DIV_W;
        S_DIV_W: begin
          if (!rdu_busy) begin
            nrm_q[gr] <= q_signed;
            if (grp_q == 4'd2) begin
              grp_q    <= '0;
              status_q <= sat_q ? ST_POS_SAT : ST_OK;
              state_q  <= S_OUT;
            end else begin
              grp_q   <= grp_q + 4'd1;
              state_q <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (out_o.ready) begin
            // The singular and zero-normal codes outrank position saturation.
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_OUT);
  assign out_o.out_pos_x  = pos_q[0];
  assign out_o.out_pos_y  = pos_q[1];
  assign out_o.out_pos_z  = pos_q[2];
  assign out_o.out_norm_x = nrm_q[0];
  assign out_o.out_norm_y = nrm_q[1];
  assign out_o.out_norm_z = nrm_q[2];
  assign out_o.status     = (status_q == ST_SINGULAR || status_q == ST_ZERO_NORMAL)
                            ? status_q : (sat_q ? ST_POS_SAT : ST_OK);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_rdu_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rdu_busy)
    else $error("root/divide unit busy while idle");

  a_return_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> in_i.ready)
    else $error("block not ready after result taken");

  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (status_q == ST_SINGULAR || status_q == ST_ZERO_NORMAL))
      |-> (nrm_q[0] == '0 && nrm_q[1] == '0 && nrm_q[2] == '0))
    else $error("nonzero normal with special status");

endmodule

`default_nettype wire
